/* rtl/npcs_pkg.sv */
`default_nettype none

package npcs_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int RAM_ADDR_W      = $clog2(PALETTE_ENTRIES);
   localparam int INDEX_SPAN      = 256;
   localparam int SPAN_W          = 11;

   localparam int IDX_W   = 8;
   localparam int CHAN_W  = 8;
   localparam int COLOR_W = 3 * CHAN_W;
   localparam int SQ_W    = 2 * CHAN_W;
   localparam int DIST_W  = 18;
   localparam int COUNT_W = 9;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last;
      logic [IDX_W-1:0] index;
   } npcs_tag_type;

endpackage

`default_nettype wire

/* rtl/npcs_palette_ram.sv */
`default_nettype none

module npcs_palette_ram
   import npcs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [RAM_ADDR_W-1:0] wr_addr,
   input  wire logic [COLOR_W-1:0]    wr_data,
   input  wire logic                  rd_en,
   input  wire logic [RAM_ADDR_W-1:0] rd_addr,
   output logic      [COLOR_W-1:0]    rd_data
);

   logic [COLOR_W-1:0] mem [PALETTE_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/npcs_dist_unit.sv */
`default_nettype none

module npcs_dist_unit
   import npcs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [COLOR_W-1:0] entry,
   input  wire logic [COLOR_W-1:0] color,
   input  wire npcs_tag_type       tag_in,
   output logic      [DIST_W-1:0]  distance,
   output npcs_tag_type            tag_out
);

   npcs_tag_type      s1_tag_ff, s2_tag_ff;
   logic [CHAN_W-1:0] s1_diff_ff [3];
   logic [CHAN_W-1:0] s1_diff_in [3];
   logic [SQ_W-1:0]   s2_sq_ff [3];
   logic [SQ_W-1:0]   s2_sq_in [3];

   always_comb begin
      logic [CHAN_W-1:0] a, b;
      for (int c = 0; c < 3; c++) begin
         a = entry[c*CHAN_W +: CHAN_W];
         b = color[c*CHAN_W +: CHAN_W];
         s1_diff_in[c] = (a > b) ? (a - b) : (b - a);
         s2_sq_in[c]   = SQ_W'(s1_diff_ff[c]) * SQ_W'(s1_diff_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
      end else begin
         s1_tag_ff <= tag_in;
         s2_tag_ff <= s1_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_diff_ff <= s1_diff_in;
      s2_sq_ff   <= s2_sq_in;
   end

   assign distance = DIST_W'(s2_sq_ff[0]) + DIST_W'(s2_sq_ff[1]) + DIST_W'(s2_sq_ff[2]);
   assign tag_out  = s2_tag_ff;

endmodule

`default_nettype wire

/* rtl/nearest_palette_color_search.sv */
// channel | dir | handshake              | payload
// req     | in  | req_tvalid/req_tready  | tuser: kind; tdata: index, red, green, blue
// rsp     | out | rsp_tvalid/rsp_tready  | tdata: match_index, match_dist
// csr     | in  | csr_valid/csr_ready    | csr_data: search_count
//
// A query scans one entry per cycle through the palette RAM read port and the
// distance pipeline, N entries with N the clamped search_count (at most 256).
// req_tready is low from the accept of a query until its result is loaded into
// the rsp register.
// Synchronous reset sets search_count to 256; palette contents stay undefined.
// A result held in the rsp register does not block writes; a later query waits
// for it only at the end of its scan.
`default_nettype none

module nearest_palette_color_search
   import npcs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,   // entry_index, red, green, blue
   input  wire logic [0:0]   req_tuser,   // kind
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [31:0]  rsp_tdata,   // match_index, match_dist, zero pad
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [8:0]   csr_data     // search_count
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_FINISH} state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0]   last_ff, last_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   npcs_tag_type       tag_rd_ff, tag_rd_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [DIST_W-1:0]  best_dist_ff, best_dist_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic [DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;

   logic               req_ok;
   logic [SPAN_W-1:0]  span;
   logic               wr_en;
   logic [COLOR_W-1:0] rd_data;
   logic [DIST_W-1:0]  distance;
   npcs_tag_type       tag_out;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_ok     = req_tvalid && req_tready;
   assign wr_en      = req_ok && (req_tuser[0] == KIND_WRITE)
                       && (SPAN_W'(req_tdata[7:0]) < SPAN_W'(PALETTE_ENTRIES));

   always_comb begin
      span = SPAN_W'(count_ff);
      if (span == '0) begin
         span = SPAN_W'(1);
      end
      if (span > SPAN_W'(PALETTE_ENTRIES)) begin
         span = SPAN_W'(PALETTE_ENTRIES);
      end
      if (span > SPAN_W'(INDEX_SPAN)) begin
         span = SPAN_W'(INDEX_SPAN);
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      addr_in      = addr_ff;
      color_in     = color_ff;
      tag_rd_in    = '0;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_dist_in  = rsp_dist_ff;

      if (csr_valid) begin
         count_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (tag_out.valid && (tag_out.first || distance < best_dist_ff)) begin
         best_idx_in  = tag_out.index;
         best_dist_in = distance;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ok && req_tuser[0] == KIND_QUERY) begin
               color_in = req_tdata[31:8];
               last_in  = IDX_W'(span - SPAN_W'(1));
               addr_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            tag_rd_in.valid = 1'b1;
            tag_rd_in.first = (addr_ff == '0);
            tag_rd_in.last  = (addr_ff == last_ff);
            tag_rd_in.index = addr_ff;
            if (addr_ff == last_ff) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (tag_out.valid && tag_out.last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = best_idx_ff;
               rsp_dist_in  = best_dist_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= COUNT_W'(INDEX_SPAN);
         tag_rd_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tag_rd_ff    <= tag_rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff      <= last_in;
      addr_ff      <= addr_in;
      color_ff     <= color_in;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_dist_ff  <= rsp_dist_in;
   end

   npcs_palette_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (RAM_ADDR_W'(req_tdata[7:0])),
      .wr_data (req_tdata[31:8]),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (RAM_ADDR_W'(addr_ff)),
      .rd_data (rd_data)
   );

   npcs_dist_unit u_dist (
      .clock    (clock),
      .reset    (reset),
      .entry    (rd_data),
      .color    (color_ff),
      .tag_in   (tag_rd_ff),
      .distance (distance),
      .tag_out  (tag_out)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_dist_ff, rsp_idx_ff};

endmodule

`default_nettype wire

/* rtl/npcs_checker.sv */
`default_nettype none

module npcs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [0:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[25:8] <= 18'd195075)
      else $error("distance out of range");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:26] == 6'd0)
      else $error("rsp pad bits set");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] |=> !req_tready)
      else $error("ready during scan");

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
